FILE: rtl/bbct_pkg.sv
// shared constants and types for the block buffer cache tag engine
`timescale 1ns / 1ps
package bbct_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int BLOCK_BITS_DEF = 24;
    localparam int DEV_W          = 16;
    localparam int COUNT_W        = 8;
    localparam int IDX_IN_W       = 6;
    localparam int IDX_OUT_W      = 6;
    localparam int IDX_IN_CODES   = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef logic [1:0] t_op;
    localparam t_op OP_GET     = 2'd0;
    localparam t_op OP_RELEASE = 2'd1;
    localparam t_op OP_FLAGS   = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_HIT      = 3'd0;
    localparam t_status ST_ALLOC    = 3'd1;
    localparam t_status ST_NOFREE   = 3'd2;
    localparam t_status ST_RELFREE  = 3'd3;
    localparam t_status ST_FLAGS    = 3'd4;
    localparam t_status ST_RELEASED = 3'd5;
    localparam t_status ST_FULL     = 3'd6;

    // per-entry count and flags as stored in the meta memory
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               dirty;
        logic               locked;
        logic               valid;
    } t_meta;

endpackage

FILE: rtl/block_buffer_cache_tags_unit.sv
// top level of the block buffer cache tag engine
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  request | in        | i_valid / o_ready  | op, device, block_number, entry_index, flags
//  result  | out       | o_valid / i_ready  | status, result_index, is_valid/locked/dirty
//
// release and flag update pass through meta read, update and result staging
// a get scans all tags one per cycle (device 0 skips the scan and counts as a miss), then on a miss walks the
// replacement ring one entry per cycle (at most ENTRIES entries) and relinks the
// victim in states S_A1 to S_A4; the tag memory port and the ring pointer chase set this pace
// after reset a clearing pass over every entry initializes all memories; o_ready is low
// a stalled result sits in the output register while the next request is accepted
`timescale 1ns / 1ps
module block_buffer_cache_tags_unit
    import bbct_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_op,
    input  logic [DEV_W-1:0]      i_device,
    input  logic [BLOCK_BITS-1:0] i_block_number,
    input  logic [IDX_IN_W-1:0]   i_entry_index,
    input  logic                  i_new_locked,
    input  logic                  i_new_dirty,
    input  logic                  i_new_valid,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_status,
    output logic [IDX_OUT_W-1:0]  o_result_index,
    output logic                  o_is_valid,
    output logic                  o_is_locked,
    output logic                  o_is_dirty
);

    localparam int IDXW = $clog2(ENTRIES);
    localparam int CNTW = IDXW + 1;
    localparam int TAGW = DEV_W + BLOCK_BITS;
    localparam int METW = $bits(t_meta);
    localparam logic [CNTW-1:0] LAST = CNTW'(ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_UPD, S_WALK, S_A1, S_A2, S_A3, S_A4, S_RESP
    } t_state;

    typedef enum logic [1:0] {K_HIT, K_REL, K_FLG} t_kind;

    t_state r_state;
    t_kind  r_kind;

    logic [CNTW-1:0]       r_cnt;
    logic                  r_spend;
    logic [IDXW-1:0]       r_pidx;
    logic [IDXW-1:0]       r_idx;
    logic [DEV_W-1:0]      r_dev;
    logic [BLOCK_BITS-1:0] r_blk;
    logic [2:0]            r_nflags;
    logic [IDXW-1:0]       r_head;
    logic                  r_wfirst;
    logic                  r_wpend;
    logic [IDXW-1:0]       r_wcur;
    logic [CNTW-1:0]       r_steps;
    logic                  r_found;
    logic [IDXW-1:0]       r_best;
    logic [1:0]            r_bbad;
    logic                  r_fwd;
    logic [IDXW-1:0]       r_p;
    logic [IDXW-1:0]       r_t;

    t_status               r_res_status;
    logic [IDXW-1:0]       r_res_idx;
    logic [2:0]            r_res_flags;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [IDX_OUT_W-1:0]  r_out_idx;
    logic [2:0]            r_out_flags;

    // memory ports
    logic            tag_we,  meta_we,  next_we,  prev_we;
    logic [IDXW-1:0] tag_wa,  meta_wa,  next_wa,  prev_wa;
    logic [IDXW-1:0] tag_ra,  meta_ra,  next_ra,  prev_ra;
    logic [TAGW-1:0] tag_wd,  tag_rd;
    t_meta           meta_wd, meta_rd;
    logic [IDXW-1:0] next_wd, next_rd, prev_wd, prev_rd;
    logic [METW-1:0] meta_rd_bits;

    bbct_ram #(.WIDTH(TAGW), .DEPTH(ENTRIES)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_wa), .i_wdata(tag_wd),
        .i_raddr(tag_ra), .o_rdata(tag_rd)
    );
    bbct_ram #(.WIDTH(METW), .DEPTH(ENTRIES)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_wa), .i_wdata(meta_wd),
        .i_raddr(meta_ra), .o_rdata(meta_rd_bits)
    );
    bbct_ram #(.WIDTH(IDXW), .DEPTH(ENTRIES)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(next_ra), .o_rdata(next_rd)
    );
    bbct_ram #(.WIDTH(IDXW), .DEPTH(ENTRIES)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(prev_ra), .o_rdata(prev_rd)
    );

    assign meta_rd = t_meta'(meta_rd_bits);

    // entry index taken modulo the entry count
    logic [IDXW-1:0] mod_tab [IDX_IN_CODES];
    for (genvar v = 0; v < IDX_IN_CODES; v++) begin : g_mod
        assign mod_tab[v] = IDXW'(v % ENTRIES);
    end

    logic [IDXW-1:0] in_idx;
    assign in_idx = mod_tab[i_entry_index];

    logic accept;
    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // tag compare in the scan
    logic scan_hit, scan_last;
    assign scan_hit  = r_spend && (tag_rd == {r_dev, r_blk});
    assign scan_last = r_spend && ({1'b0, r_pidx} == LAST);

    // ring walk evaluation of the entry read last cycle
    logic [1:0]      w_bad;
    logic            w_cand, w_stop, w_found;
    logic [IDXW-1:0] w_best, walk_addr;
    assign w_bad     = {meta_rd.dirty, meta_rd.locked};
    assign w_cand    = r_wpend && (meta_rd.count == '0) && (!r_found || (w_bad < r_bbad));
    assign w_stop    = r_wpend && ((w_cand && (w_bad == 2'd0)) || (r_steps == LAST));
    assign w_found   = r_found || w_cand;
    assign w_best    = w_cand ? r_wcur : r_best;
    assign walk_addr = r_wfirst ? r_head : next_rd;

    // relink helpers
    logic [IDXW-1:0] a2_head, a3_tail;
    assign a2_head = (r_head == r_best) ? next_rd : r_head;
    assign a3_tail = r_fwd ? r_p : prev_rd;

    // clearing values
    logic [IDXW-1:0] clr_idx, clr_next, clr_prev;
    assign clr_idx  = r_cnt[IDXW-1:0];
    assign clr_next = (r_cnt == LAST) ? '0 : IDXW'(r_cnt + 1'b1);
    assign clr_prev = (r_cnt == '0) ? LAST[IDXW-1:0] : IDXW'(r_cnt - 1'b1);

    // entry update for hit, release and flag update
    t_meta   upd_meta;
    t_status upd_status;
    always_comb begin
        upd_meta   = meta_rd;
        upd_status = ST_FLAGS;
        case (r_kind)
            K_HIT: begin
                if (meta_rd.count == COUNT_MAX) begin
                    upd_status = ST_FULL;
                end else begin
                    upd_meta.count = meta_rd.count + 1'b1;
                    upd_status     = ST_HIT;
                end
            end
            K_REL: begin
                if (meta_rd.count == '0) begin
                    upd_status = ST_RELFREE;
                end else begin
                    upd_meta.count = meta_rd.count - 1'b1;
                    upd_status     = ST_RELEASED;
                end
            end
            default: begin
                upd_meta.locked = r_nflags[2];
                upd_meta.dirty  = r_nflags[1];
                upd_meta.valid  = r_nflags[0];
            end
        endcase
    end

    // memory address and write control
    always_comb begin
        tag_we  = 1'b0;  tag_wa  = r_best; tag_wd  = {r_dev, r_blk};
        meta_we = 1'b0;  meta_wa = r_idx;  meta_wd = upd_meta;
        next_we = 1'b0;  next_wa = r_best; next_wd = r_head;
        prev_we = 1'b0;  prev_wa = r_best; prev_wd = a3_tail;
        tag_ra  = r_cnt[IDXW-1:0];
        meta_ra = r_idx;
        next_ra = r_best;
        prev_ra = r_best;
        unique case (r_state)
            S_CLEAR: begin
                tag_we  = 1'b1; tag_wa  = clr_idx; tag_wd  = '0;
                meta_we = 1'b1; meta_wa = clr_idx; meta_wd = '0;
                next_we = 1'b1; next_wa = clr_idx; next_wd = clr_next;
                prev_we = 1'b1; prev_wa = clr_idx; prev_wd = clr_prev;
            end
            S_IDLE: meta_ra = in_idx;
            S_SCAN: meta_ra = r_pidx;
            S_UPD:  meta_we = 1'b1;
            S_WALK: begin
                meta_ra = walk_addr;
                next_ra = walk_addr;
            end
            S_A1: begin
                tag_we  = 1'b1;
                meta_we = 1'b1;
                meta_wa = r_best;
                meta_wd = '{count: COUNT_W'(1), dirty: 1'b0, locked: 1'b0, valid: 1'b0};
            end
            S_A2: begin
                next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
                prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
                prev_ra = a2_head;
            end
            S_A3: begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            S_A4: begin
                next_we = 1'b1; next_wa = r_t;    next_wd = r_best;
                prev_we = 1'b1; prev_wa = r_head; prev_wd = r_best;
            end
            default: ;
        endcase
    end

    // control state machine and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_head      <= '0;
            r_spend     <= 1'b0;
            r_wpend     <= 1'b0;
            r_wfirst    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // result slot: filled from the response state, emptied by the receiver
            if (r_state == S_RESP && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_head <= '0;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_dev    <= i_device;
                    r_blk    <= i_block_number;
                    r_idx    <= in_idx;
                    r_nflags <= {i_new_locked, i_new_dirty, i_new_valid};
                    r_cnt    <= '0;
                    r_spend  <= 1'b0;
                    r_wpend  <= 1'b0;
                    r_wfirst <= 1'b1;
                    r_steps  <= '0;
                    r_found  <= 1'b0;
                    if (accept) begin
                        case (i_op)
                            OP_GET:     r_state <= (i_device == '0) ? S_WALK : S_SCAN;
                            OP_RELEASE: begin r_kind <= K_REL; r_state <= S_UPD; end
                            OP_FLAGS:   begin r_kind <= K_FLG; r_state <= S_UPD; end
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_cnt != CNTW'(ENTRIES)) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_pidx  <= r_cnt[IDXW-1:0];
                        r_spend <= 1'b1;
                    end else begin
                        r_spend <= 1'b0;
                    end
                    if (scan_hit) begin
                        r_kind  <= K_HIT;
                        r_idx   <= r_pidx;
                        r_state <= S_UPD;
                    end else if (scan_last) begin
                        r_state <= S_WALK;
                    end
                end
                S_UPD: begin
                    r_res_status <= upd_status;
                    r_res_idx    <= r_idx;
                    r_res_flags  <= {upd_meta.valid, upd_meta.locked, upd_meta.dirty};
                    r_state      <= S_RESP;
                end
                S_WALK: begin
                    r_wfirst <= 1'b0;
                    r_wpend  <= !w_stop;
                    r_wcur   <= walk_addr;
                    if (r_wpend) begin
                        r_steps <= r_steps + 1'b1;
                        r_found <= w_found;
                        r_best  <= w_best;
                        if (w_cand) begin
                            r_bbad <= w_bad;
                        end
                    end
                    if (w_stop) begin
                        if (w_found) begin
                            r_state <= S_A1;
                        end else begin
                            r_res_status <= ST_NOFREE;
                            r_res_idx    <= '0;
                            r_res_flags  <= '0;
                            r_state      <= S_RESP;
                        end
                    end
                end
                S_A1: r_state <= S_A2;
                S_A2: begin
                    r_head  <= a2_head;
                    r_fwd   <= (a2_head == next_rd);
                    r_p     <= prev_rd;
                    r_state <= S_A3;
                end
                S_A3: begin
                    r_t     <= a3_tail;
                    r_state <= S_A4;
                end
                S_A4: begin
                    r_res_status <= ST_ALLOC;
                    r_res_idx    <= r_best;
                    r_res_flags  <= '0;
                    r_state      <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    logic [IDXW+IDX_OUT_W-1:0] res_idx_ext;
    assign res_idx_ext = {{IDX_OUT_W{1'b0}}, r_res_idx};

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP && (!r_out_valid || i_ready)) begin
            r_out_status <= r_res_status;
            r_out_idx    <= res_idx_ext[IDX_OUT_W-1:0];
            r_out_flags  <= r_res_flags;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_index = r_out_idx;
    assign o_is_valid     = r_out_flags[2];
    assign o_is_locked    = r_out_flags[1];
    assign o_is_dirty     = r_out_flags[0];

`ifndef SYNTHESIS
    // no request taken while the memories are being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready)
        else $error("request accepted during clearing pass");

    // the ring walk never evaluates more entries than exist
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps <= CNTW'(ENTRIES)))
        else $error("ring walk overran the entry count");

    // an allocation always follows a found victim
    a_alloc_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A1) |-> r_found)
        else $error("allocation without a victim");

    // a result leaves the response state only into an empty or draining slot
    a_resp_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_valid && !i_ready) |=> (r_state == S_RESP))
        else $error("result dropped while output stalled");
`endif

endmodule

FILE: rtl/bbct_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
`timescale 1ns / 1ps
module bbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: test/tb_block_buffer_cache_tags_unit.sv
// testbench for the block buffer cache tag engine: directed and random transactions
`timescale 1ns / 1ps
module tb_block_buffer_cache_tags_unit;
    import bbct_pkg::*;

    localparam int NENT      = ENTRIES_DEF;
    localparam int WDOG_MAX  = 20000;
    localparam int TAIL_WAIT = 600;

    // request and result shapes
    typedef struct packed {
        t_op                     op;
        logic [DEV_W-1:0]        device;
        logic [BLOCK_BITS_DEF-1:0] blk;
        logic [IDX_IN_W-1:0]     idx;
        logic                    lk;
        logic                    dt;
        logic                    vl;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [IDX_OUT_W-1:0] index;
        logic                 valid;
        logic                 locked;
        logic                 dirty;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_op = '0;
    logic [DEV_W-1:0] i_device = '0;
    logic [BLOCK_BITS_DEF-1:0] i_block_number = '0;
    logic [IDX_IN_W-1:0] i_entry_index = '0;
    logic i_new_locked = 1'b0;
    logic i_new_dirty = 1'b0;
    logic i_new_valid = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [2:0] o_status;
    logic [IDX_OUT_W-1:0] o_result_index;
    logic o_is_valid, o_is_locked, o_is_dirty;

    always #1 i_clk = ~i_clk;

    block_buffer_cache_tags_unit dut (.*);

    // cache shadow state
    logic [DEV_W-1:0]          sh_dev   [NENT];
    logic [BLOCK_BITS_DEF-1:0] sh_blk   [NENT];
    logic [COUNT_W-1:0]        sh_cnt   [NENT];
    logic                      sh_dirty [NENT];
    logic                      sh_lock  [NENT];
    logic                      sh_valid [NENT];
    logic [5:0]                sh_next  [NENT];
    logic [5:0]                sh_prev  [NENT];
    logic [5:0]                sh_head;

    t_res pending_results[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_recv = 1'b0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   sent = 0;
    int   idle_cycles = 0;
    int   n_hit = 0, n_alloc = 0, n_nofree = 0, n_full = 0;

    function automatic t_res entry_result(t_status st, int e);
        t_res r;
        r.status = st;
        r.index  = e[5:0];
        r.valid  = sh_valid[e];
        r.locked = sh_lock[e];
        r.dirty  = sh_dirty[e];
        return r;
    endfunction

    function automatic int entry_badness(int e);
        return 2 * sh_dirty[e] + sh_lock[e];
    endfunction

    task automatic shadow_reset();
        for (int i = 0; i < NENT; i++) begin
            sh_dev[i] = '0; sh_blk[i] = '0; sh_cnt[i] = '0;
            sh_dirty[i] = 0; sh_lock[i] = 0; sh_valid[i] = 0;
            sh_next[i] = 6'((i + 1) % NENT);
            sh_prev[i] = 6'((i + NENT - 1) % NENT);
        end
        sh_head = '0;
    endtask

    // unlink the victim and reinsert it just before the head
    task automatic ring_to_tail(int e);
        int n, p, h, t;
        n = sh_next[e];
        p = sh_prev[e];
        sh_next[p] = 6'(n);
        sh_prev[n] = 6'(p);
        if (sh_head == e) sh_head = 6'(n);
        h = sh_head;
        t = sh_prev[h];
        sh_next[e] = 6'(h);
        sh_prev[e] = 6'(t);
        sh_next[t] = 6'(e);
        sh_prev[h] = 6'(e);
    endtask

    // predict the result of one request and update the shadow
    task automatic predict_cache_op(t_req q);
        int cur, best;
        bit found;
        t_res r;
        found = 0;
        best = 0;
        if (q.op == OP_GET) begin
            if (q.device != 0) begin
                for (int i = 0; i < NENT; i++) begin
                    if (sh_dev[i] == q.device && sh_blk[i] == q.blk) begin
                        if (sh_cnt[i] == COUNT_MAX) begin
                            pending_results.push_back(entry_result(ST_FULL, i));
                        end else begin
                            sh_cnt[i]++;
                            pending_results.push_back(entry_result(ST_HIT, i));
                        end
                        return;
                    end
                end
            end
            cur = sh_head;
            for (int s = 0; s < NENT; s++) begin
                if (sh_cnt[cur] == 0 &&
                    (!found || entry_badness(cur) < entry_badness(best))) begin
                    best = cur;
                    found = 1;
                    if (entry_badness(cur) == 0) break;
                end
                cur = sh_next[cur];
            end
            if (!found) begin
                r = '0;
                r.status = ST_NOFREE;
                pending_results.push_back(r);
                return;
            end
            sh_cnt[best] = 1;
            sh_dirty[best] = 0; sh_lock[best] = 0; sh_valid[best] = 0;
            sh_dev[best] = q.device;
            sh_blk[best] = q.blk;
            ring_to_tail(best);
            pending_results.push_back(entry_result(ST_ALLOC, best));
        end else if (q.op == OP_RELEASE) begin
            if (sh_cnt[q.idx] == 0) begin
                pending_results.push_back(entry_result(ST_RELFREE, q.idx));
            end else begin
                sh_cnt[q.idx]--;
                pending_results.push_back(entry_result(ST_RELEASED, q.idx));
            end
        end else if (q.op == OP_FLAGS) begin
            sh_lock[q.idx] = q.lk;
            sh_dirty[q.idx] = q.dt;
            sh_valid[q.idx] = q.vl;
            pending_results.push_back(entry_result(ST_FLAGS, q.idx));
        end
    endtask

    // send one transaction, with optional idle cycles before it
    task automatic send_request(t_req q);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= q.op;
        i_device <= q.device;
        i_block_number <= q.blk;
        i_entry_index <= q.idx;
        i_new_locked <= q.lk;
        i_new_dirty <= q.dt;
        i_new_valid <= q.vl;
        do @(posedge i_clk); while (!o_ready);
        predict_cache_op(q);
        sent++;
    endtask

    function automatic t_req make_req(t_op op, int dev, int blk, int idx, bit lk = 0,
                                      bit dt = 0, bit vl = 0);
        t_req q;
        q.op = op;
        q.device = DEV_W'(dev);
        q.blk = BLOCK_BITS_DEF'(blk);
        q.idx = IDX_IN_W'(idx);
        q.lk = lk; q.dt = dt; q.vl = vl;
        return q;
    endfunction

    // stop offering and wait for every expected result
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver ready generation
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_recv)
            i_ready <= 1'b0;
        else
            i_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_status, o_result_index, o_is_valid, o_is_locked, o_is_dirty};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d index=%0d", o_status,
                             o_result_index);
            end else begin
                want = pending_results.pop_front();
                case (want.status)
                    ST_HIT: n_hit++;
                    ST_ALLOC: n_alloc++;
                    ST_NOFREE: n_nofree++;
                    ST_FULL: n_full++;
                    default: ;
                endcase
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d idx=%0d v=%b l=%b d=%b, %s",
                                 want.status, want.index, want.valid, want.locked,
                                 want.dirty,
                                 $sformatf("got st=%0d idx=%0d v=%b l=%b d=%b",
                                           got.status, got.index, got.valid,
                                           got.locked, got.dirty));
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("tb_block_buffer_cache_tags_unit: errors");
            $finish;
        end
    end

    // extremes of every field, every op and each special case
    task automatic test_directed();
        send_request(make_req(OP_RELEASE, 0, 0, 0));
        send_request(make_req(OP_GET, 0, 0, 0));
        send_request(make_req(OP_GET, 0, 0, 0));
        send_request(make_req(OP_GET, 16'hFFFF, 24'hFFFFFF, 0));
        send_request(make_req(OP_GET, 16'hFFFF, 24'hFFFFFF, 0));
        send_request(make_req(OP_GET, 1, 0, 0));
        send_request(make_req(OP_FLAGS, 0, 0, 63, 1, 1, 1));
        send_request(make_req(OP_FLAGS, 0, 0, 62, 1, 0, 0));
        send_request(make_req(OP_FLAGS, 0, 0, 61, 0, 1, 0));
        send_request(make_req(OP_RELEASE, 0, 0, 2));
        send_request(make_req(OP_RELEASE, 0, 0, 2));
        send_request(make_req(OP_RELEASE, 0, 0, 63));
        send_request(make_req(OP_FLAGS, 0, 0, 2, 0, 0, 0));
        send_request(make_req(3, 16'hFFFF, 24'hFFFFFF, 63, 1, 1, 1));
        send_request(make_req(OP_GET, 7, 5, 0));
        send_request(make_req(OP_RELEASE, 0, 0, 3));
        drain_results();
    endtask

    // fill every entry, then miss with no free entry
    task automatic test_no_free();
        for (int i = 0; i < NENT; i++)
            send_request(make_req(OP_GET, 100, i, 0));
        send_request(make_req(OP_GET, 101, 0, 0));
        for (int i = 0; i < NENT; i++)
            send_request(make_req(OP_RELEASE, 0, 0, i));
        drain_results();
    endtask

    // push one entry's count to the ceiling
    task automatic test_count_full();
        for (int i = 0; i < 257; i++)
            send_request(make_req(OP_GET, 200, 9, 0));
        for (int i = 0; i < NENT; i++)
            send_request(make_req(OP_RELEASE, 0, 0, i));
        drain_results();
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_request(make_req(OP_FLAGS, 0, 0, i, i[0], i[1], i[2]));
        join
        drain_results();
    endtask

    // random mix of gets, releases and flag updates over a small tag space
    task automatic test_random(int count, int s_pct, int r_pct);
        t_req q;
        int k;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            q = make_req(OP_GET, $urandom_range(1, 4), $urandom_range(0, 40),
                         $urandom_range(0, 63), $urandom_range(1), $urandom_range(1),
                         $urandom_range(1));
            if (k < 4) begin
                q.device = DEV_W'($urandom);
                q.blk = BLOCK_BITS_DEF'($urandom);
            end else if (k < 6) begin
                q.device = '0;
            end
            if (k >= 45 && k < 75) q.op = OP_RELEASE;
            else if (k >= 75 && k < 97) q.op = OP_FLAGS;
            else if (k >= 97) q.op = 2'd3;
            send_request(q);
        end
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        shadow_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_no_free();
        test_count_full();
        test_backpressure();
        test_random(180, 0, 0);
        test_random(180, 68, 0);
        test_random(180, 0, 68);
        test_random(180, 29, 29);
        test_random(55, 0, 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("sent %0d requests, checked %0d results", sent, results_seen);
        $display("hits %0d, allocations %0d, no-free %0d, count-full %0d, mismatches %0d",
                 n_hit, n_alloc, n_nofree, n_full, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_block_buffer_cache_tags_unit: clean");
        else
            $display("tb_block_buffer_cache_tags_unit: errors");
        $finish;
    end

endmodule
